// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion shorthands for the read request queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define TPRQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define TPRQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Consequent holds in the cycle after the antecedent.
`define TPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// ===== rtl/tprq_pkg.sv =====
// tprq_pkg: constants, codes and word types of the two-priority read request queue.
// No dependencies; compiled before every other file of the block.
package tprq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PRIORITY_LEVELS = 2;
    localparam int FILE_SLOTS      = 32;
    localparam int CMD_FIFO_DEPTH  = 2;

    typedef enum logic [2:0] {
        EV_REFUSED      = 3'd0,
        EV_ACCEPTED     = 3'd1,
        EV_ISSUE        = 3'd2,
        EV_DONE_HANDLER = 3'd3,
        EV_DONE_PLAIN   = 3'd4
    } event_kind_t;

    typedef enum logic [0:0] {
        FUNC_ENQUEUE  = 1'b0,
        FUNC_COMPLETE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_REFUSE,
        CMD_DONE_OK,
        CMD_DONE_ERR
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    typedef enum logic [0:0] {
        RD_ISSUE,
        RD_DONE
    } read_use_t;

    typedef struct packed {
        logic [4:0]         file_slot;
        logic [31:0]        buf_addr;
        logic [31:0]        read_length;
        logic [31:0]        read_offset;
        logic [31:0]        callback_tag;
        logic               short_callback;
        logic signed [31:0] user_word;
        logic [7:0]         user_flag;
    } req_t;

    typedef struct packed {
        cmd_op_t op;
        logic    prio;
        req_t    req;
    } cmd_t;

    typedef struct packed {
        event_kind_t kind;
        logic        prio;
        req_t        req;
        logic        last;
    } res_t;

endpackage

// ===== rtl/tprq_in_if.sv =====
// tprq_in_if: request channel word (enqueue or completion) with valid/ready handshake.
// No dependencies.
interface tprq_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic               priority_req;
    logic [4:0]         file_slot;
    logic [31:0]        buf_addr;
    logic [31:0]        read_length;
    logic [31:0]        read_offset;
    logic [31:0]        callback_tag;
    logic               short_callback;
    logic signed [31:0] user_word;
    logic [7:0]         user_flag;
    logic signed [31:0] done_result;

    modport source (
        output valid, func, priority_req, file_slot, buf_addr, read_length, read_offset,
               callback_tag, short_callback, user_word, user_flag, done_result,
        input  ready
    );

    modport sink (
        input  valid, func, priority_req, file_slot, buf_addr, read_length, read_offset,
               callback_tag, short_callback, user_word, user_flag, done_result,
        output ready
    );
endinterface

// ===== rtl/tprq_out_if.sv =====
// tprq_out_if: result channel word (event and request fields) with valid/ready handshake.
// No dependencies.
interface tprq_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic               out_priority;
    logic [4:0]         out_file_slot;
    logic [31:0]        out_buf_addr;
    logic [31:0]        out_length;
    logic [31:0]        out_offset;
    logic [31:0]        out_callback_tag;
    logic               out_short_callback;
    logic signed [31:0] out_user_word;
    logic [7:0]         out_user_flag;
    logic               last;

    modport source (
        output valid, event_kind, out_priority, out_file_slot, out_buf_addr, out_length,
               out_offset, out_callback_tag, out_short_callback, out_user_word,
               out_user_flag, last,
        input  ready
    );

    modport sink (
        input  valid, event_kind, out_priority, out_file_slot, out_buf_addr, out_length,
               out_offset, out_callback_tag, out_short_callback, out_user_word,
               out_user_flag, last,
        output ready
    );
endinterface

// ===== rtl/two_priority_read_request_queue.sv =====
// Path: front register, command queue, back end. An enqueue is answered from idle, also
// through read and emit when it issues; a completion through read and emit, again if it
// issues next. A new command is taken only in idle with the result register free.
// Reset: rst_n asynchronous, active low; clears queue pointers, counts, busy, command queue
// and result valid. The entry memory is not cleared; only written entries are ever read.
module two_priority_read_request_queue #(
    parameter int QUEUE_DEPTH = tprq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tprq_in_if.sink    request,
    tprq_out_if.source result
);
    import tprq_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    tprq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    tprq_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    tprq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .result    (result)
    );

endmodule

// ===== rtl/tprq_front.sv =====
// tprq_front: accepts request words, classifies them into queue commands and holds one.
// Depends on tprq_pkg and tprq_in_if.
module tprq_front (
    input  logic            clk,
    input  logic            rst_n,
    tprq_in_if.sink         request,
    output tprq_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import tprq_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t class_cmd;
    logic take;

    assign request.ready = !hold_valid_reg || cmd_ready;
    assign take          = request.valid && request.ready;
    assign cmd_valid     = hold_valid_reg;
    assign cmd           = hold_cmd_reg;

    always_comb
    begin
        class_cmd.prio               = request.priority_req;
        class_cmd.req.file_slot      = request.file_slot;
        class_cmd.req.buf_addr       = request.buf_addr;
        class_cmd.req.read_length    = request.read_length;
        class_cmd.req.read_offset    = request.read_offset;
        class_cmd.req.callback_tag   = request.callback_tag;
        class_cmd.req.short_callback = request.short_callback;
        class_cmd.req.user_word      = request.user_word;
        class_cmd.req.user_flag      = request.user_flag;
        if (request.func == FUNC_ENQUEUE)
        begin
            class_cmd.op = (32'(request.file_slot) >= FILE_SLOTS) ? CMD_REFUSE : CMD_ENQ;
        end
        else
        begin
            class_cmd.op = request.done_result[31] ? CMD_DONE_ERR : CMD_DONE_OK;
        end
    end

    always_comb
    begin
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_cmd_reg <= class_cmd;
        end
    end

endmodule

// ===== rtl/tprq_cmd_fifo.sv =====
// tprq_cmd_fifo: short command queue that decouples the front classifier from the back end.
// Depends on tprq_pkg.
module tprq_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  tprq_pkg::cmd_t  push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output tprq_pkg::cmd_t  pop_cmd,
    output logic            pop_valid,
    input  logic            pop_ready
);
    import tprq_pkg::*;

    localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(CMD_FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(CMD_FIFO_DEPTH);

    cmd_t          slot_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          push;
    logic          pop;

    assign push_ready = (fill_reg != FULL_FILL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/tprq_back.sv =====
// tprq_back: per-priority ring queues in an entry memory, issue sequencer and result register.
// Depends on tprq_pkg, tprq_out_if and assert_macros.svh.
`include "assert_macros.svh"

module tprq_back #(
    parameter int QUEUE_DEPTH = tprq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tprq_pkg::cmd_t  cmd,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    tprq_out_if.source      result
);
    import tprq_pkg::*;

    localparam int QW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = PRIORITY_LEVELS * (2 ** QW);
    localparam int AW      = QW + 1;
    localparam logic [QW-1:0] LAST_POS   = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   WRAP_SUM   = (CW + 1)'(QUEUE_DEPTH);

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [QW-1:0] head_reg  [PRIORITY_LEVELS];
    logic [QW-1:0] head_next [PRIORITY_LEVELS];
    logic [CW-1:0] count_reg  [PRIORITY_LEVELS];
    logic [CW-1:0] count_next [PRIORITY_LEVELS];
    logic          busy_reg;
    logic          busy_next;
    logic          busy_prio_reg;
    logic          busy_prio_next;
    read_use_t     use_reg;
    read_use_t     use_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          out_reg;
    res_t          out_next;

    req_t          mem [ENTRIES];
    req_t          mem_rd_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    logic          out_free;
    logic [CW:0]   tail_sum;
    logic [QW-1:0] tail;
    req_t          echo_req;
    logic          has_handler;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        tail_sum = (CW + 1)'(head_reg[cmd.prio]) + (CW + 1)'(count_reg[cmd.prio]);
        if (tail_sum >= WRAP_SUM)
        begin
            tail_sum = tail_sum - WRAP_SUM;
        end
        tail = tail_sum[QW-1:0];
    end

    always_comb
    begin
        echo_req                = cmd.req;
        echo_req.callback_tag   = '0;
        echo_req.short_callback = 1'b0;
        echo_req.user_word      = '0;
        echo_req.user_flag      = '0;
    end

    assign has_handler = (mem_rd_reg.callback_tag != '0);
    assign mem_waddr   = {cmd.prio, tail};
    assign mem_raddr   = {busy_prio_reg, head_reg[busy_prio_reg]};

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;
        busy_prio_next = busy_prio_reg;
        use_next       = use_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.op)
                        CMD_REFUSE:
                        begin
                            out_valid_next = 1'b1;
                            out_next.kind  = EV_REFUSED;
                            out_next.prio  = cmd.prio;
                            out_next.req   = echo_req;
                            out_next.last  = 1'b1;
                        end
                        CMD_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            out_next.prio  = cmd.prio;
                            out_next.req   = echo_req;
                            if (count_reg[cmd.prio] >= FULL_COUNT)
                            begin
                                out_next.kind = EV_REFUSED;
                                out_next.last = 1'b1;
                            end
                            else
                            begin
                                mem_we                = 1'b1;
                                count_next[cmd.prio]  = count_reg[cmd.prio] + 1'b1;
                                out_next.kind         = EV_ACCEPTED;
                                out_next.last         = busy_reg;
                                if (!busy_reg)
                                begin
                                    busy_next      = 1'b1;
                                    busy_prio_next = (count_next[0] != '0) ? 1'b0 : 1'b1;
                                    use_next       = RD_ISSUE;
                                    state_next     = BK_READ;
                                end
                            end
                        end
                        CMD_DONE_OK, CMD_DONE_ERR:
                        begin
                            if (busy_reg)
                            begin
                                use_next   = (cmd.op == CMD_DONE_ERR) ? RD_ISSUE : RD_DONE;
                                state_next = BK_READ;
                            end
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                mem_re     = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.prio  = busy_prio_reg;
                    out_next.req   = mem_rd_reg;
                    if (use_reg == RD_ISSUE)
                    begin
                        out_next.kind                = EV_ISSUE;
                        out_next.req.callback_tag    = '0;
                        out_next.req.short_callback  = 1'b0;
                        out_next.req.user_word       = '0;
                        out_next.req.user_flag       = '0;
                        out_next.last                = 1'b1;
                        state_next                   = BK_IDLE;
                    end
                    else
                    begin
                        out_next.kind = has_handler ? EV_DONE_HANDLER : EV_DONE_PLAIN;
                        if (!has_handler)
                        begin
                            out_next.req.short_callback = 1'b0;
                            out_next.req.user_word      = '0;
                            out_next.req.user_flag      = '0;
                        end
                        head_next[busy_prio_reg]  = (head_reg[busy_prio_reg] == LAST_POS) ?
                                                    '0 : head_reg[busy_prio_reg] + 1'b1;
                        count_next[busy_prio_reg] = count_reg[busy_prio_reg] - 1'b1;
                        if ((count_next[0] != '0) || (count_next[1] != '0))
                        begin
                            busy_next      = 1'b1;
                            busy_prio_next = (count_next[0] != '0) ? 1'b0 : 1'b1;
                            use_next       = RD_ISSUE;
                            out_next.last  = 1'b0;
                            state_next     = BK_READ;
                        end
                        else
                        begin
                            busy_next     = 1'b0;
                            out_next.last = 1'b1;
                            state_next    = BK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            busy_reg      <= 1'b0;
            busy_prio_reg <= 1'b0;
            use_reg       <= RD_ISSUE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            busy_prio_reg <= busy_prio_next;
            use_reg       <= use_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.req;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_raddr];
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.event_kind         = out_reg.kind;
    assign result.out_priority       = out_reg.prio;
    assign result.out_file_slot      = out_reg.req.file_slot;
    assign result.out_buf_addr       = out_reg.req.buf_addr;
    assign result.out_length         = out_reg.req.read_length;
    assign result.out_offset         = out_reg.req.read_offset;
    assign result.out_callback_tag   = out_reg.req.callback_tag;
    assign result.out_short_callback = out_reg.req.short_callback;
    assign result.out_user_word      = out_reg.req.user_word;
    assign result.out_user_flag      = out_reg.req.user_flag;
    assign result.last               = out_reg.last;

    `TPRQ_ASSERT_ALWAYS(a_count_bound_hi, clk, rst_n, count_reg[0] <= FULL_COUNT)
    `TPRQ_ASSERT_ALWAYS(a_count_bound_lo, clk, rst_n, count_reg[1] <= FULL_COUNT)
    `TPRQ_ASSERT_IMPLY(a_idle_empty, clk, rst_n, !busy_reg, (count_reg[0] | count_reg[1]) == '0)
    `TPRQ_ASSERT_IMPLY(a_busy_nonempty, clk, rst_n, busy_reg, count_reg[busy_prio_reg] != '0)
    `TPRQ_ASSERT_IMPLY(a_seq_in_flight, clk, rst_n, state_reg != BK_IDLE, busy_reg)
    `TPRQ_ASSERT_NEXT(a_read_then_emit, clk, rst_n, state_reg == BK_READ, state_reg == BK_EMIT)

endmodule

// ===== tb/tprq_checker.sv =====
`timescale 1ns / 1ps
// tprq_checker: watches the request and result channels of the read request queue,
// predicts the events of every accepted request word and compares the result words.
// Depends on tprq_pkg and the tprq_in_if / tprq_out_if interfaces.
module tprq_checker (
    input  logic clk,
    input  logic rst_n,
    tprq_in_if   request,
    tprq_out_if  result,
    output int   fail_count,
    output int   backlog
);
    import tprq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    req_t        entry_mem [PRIORITY_LEVELS*DEPTH];
    int unsigned head_idx [PRIORITY_LEVELS];
    int unsigned fill [PRIORITY_LEVELS];
    logic        in_flight;
    logic        flight_prio;
    res_t        expected_events [$];
    res_t        word_events [$];

    initial
    begin
        fail_count   = 0;
        backlog      = 0;
        in_flight    = 1'b0;
        flight_prio  = 1'b0;
        for (int p = 0; p < PRIORITY_LEVELS; p++)
        begin
            head_idx[p] = 0;
            fill[p]     = 0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic res_t echo_event(input event_kind_t kind, input logic prio,
                                        input req_t rq);
        res_t r;
        r                  = '0;
        r.kind             = kind;
        r.prio             = prio;
        r.req.file_slot    = rq.file_slot;
        r.req.buf_addr     = rq.buf_addr;
        r.req.read_length  = rq.read_length;
        r.req.read_offset  = rq.read_offset;
        return r;
    endfunction

    function automatic res_t entry_event(input event_kind_t kind, input logic prio,
                                         input logic with_handler);
        req_t e;
        res_t r;
        e = entry_mem[int'(prio) * DEPTH + head_idx[prio]];
        r = echo_event(kind, prio, e);
        if (kind == EV_DONE_HANDLER || kind == EV_DONE_PLAIN)
            r.req.callback_tag = e.callback_tag;
        if (with_handler)
        begin
            r.req.short_callback = e.short_callback;
            r.req.user_word      = e.user_word;
            r.req.user_flag      = e.user_flag;
        end
        return r;
    endfunction

    task automatic issue_next();
        for (int p = 0; p < PRIORITY_LEVELS && !in_flight; p++)
        begin
            if (fill[p] > 0)
            begin
                in_flight   = 1'b1;
                flight_prio = p[0];
                word_events.push_back(entry_event(EV_ISSUE, p[0], 1'b0));
            end
        end
    endtask

    task automatic predict_events(input logic func, input logic prio, input req_t rq,
                                  input logic signed [31:0] done);
        logic has_handler;
        int   idx;
        word_events.delete();
        if (func == FUNC_ENQUEUE)
        begin
            if (fill[prio] >= DEPTH || rq.file_slot >= FILE_SLOTS)
                word_events.push_back(echo_event(EV_REFUSED, prio, rq));
            else
            begin
                idx = int'(prio) * DEPTH + (head_idx[prio] + fill[prio]) % DEPTH;
                entry_mem[idx] = rq;
                fill[prio]++;
                word_events.push_back(echo_event(EV_ACCEPTED, prio, rq));
                issue_next();
            end
        end
        else if (in_flight)
        begin
            if (done < 0)
                word_events.push_back(entry_event(EV_ISSUE, flight_prio, 1'b0));
            else
            begin
                idx = int'(flight_prio) * DEPTH + head_idx[flight_prio];
                has_handler = (entry_mem[idx].callback_tag != 0);
                word_events.push_back(entry_event(has_handler ? EV_DONE_HANDLER : EV_DONE_PLAIN,
                                                  flight_prio, has_handler));
                head_idx[flight_prio] = (head_idx[flight_prio] + 1) % DEPTH;
                fill[flight_prio]--;
                in_flight = 1'b0;
                issue_next();
            end
        end
        else
            issue_next();
        if (word_events.size() > 0)
            word_events[word_events.size() - 1].last = 1'b1;
        foreach (word_events[i])
            expected_events.push_back(word_events[i]);
    endtask

    always @(posedge clk)
    begin
        req_t rq;
        res_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                rq.file_slot      = request.file_slot;
                rq.buf_addr       = request.buf_addr;
                rq.read_length    = request.read_length;
                rq.read_offset    = request.read_offset;
                rq.callback_tag   = request.callback_tag;
                rq.short_callback = request.short_callback;
                rq.user_word      = request.user_word;
                rq.user_flag      = request.user_flag;
                predict_events(request.func, request.priority_req, rq, request.done_result);
            end
            if (result.valid && result.ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("result word with nothing expected, event_kind",
                                    32'(result.event_kind), '0);
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 32'(result.event_kind), 32'(want.kind));
                    check_field("out_priority", 32'(result.out_priority), 32'(want.prio));
                    check_field("out_file_slot", 32'(result.out_file_slot),
                                32'(want.req.file_slot));
                    check_field("out_buf_addr", result.out_buf_addr, want.req.buf_addr);
                    check_field("out_length", result.out_length, want.req.read_length);
                    check_field("out_offset", result.out_offset, want.req.read_offset);
                    check_field("out_callback_tag", result.out_callback_tag,
                                want.req.callback_tag);
                    check_field("out_short_callback", 32'(result.out_short_callback),
                                32'(want.req.short_callback));
                    check_field("out_user_word", result.out_user_word, want.req.user_word);
                    check_field("out_user_flag", 32'(result.out_user_flag),
                                32'(want.req.user_flag));
                    check_field("last", 32'(result.last), 32'(want.last));
                end
            end
            backlog <= expected_events.size();
        end
    end

endmodule

// ===== tb/tb_two_priority_read_request_queue.sv =====
`timescale 1ns / 1ps
// tb_two_priority_read_request_queue: drives request words into the read request queue
// and stalls the result channel at random; the verdict comes from tprq_checker.
// Depends on tprq_pkg, tprq_in_if, tprq_out_if, the block and tprq_checker.
module tb_two_priority_read_request_queue;
    import tprq_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_WORDS = 415;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        func_t              func;
        logic               prio;
        req_t               req;
        logic signed [31:0] done;
    } word_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   backlog;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests;
    int   holds_done;
    int   cycles;

    tprq_in_if  request_ch ();
    tprq_out_if result_ch ();

    two_priority_read_request_queue u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    tprq_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .backlog      (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t make_enq(input logic prio, input logic [4:0] slot,
                                       input logic [31:0] addr, input logic [31:0] len,
                                       input logic [31:0] off, input logic [31:0] tag,
                                       input logic shrt, input logic [31:0] uword,
                                       input logic [7:0] uflag);
        word_t w;
        w.func               = FUNC_ENQUEUE;
        w.prio               = prio;
        w.req.file_slot      = slot;
        w.req.buf_addr       = addr;
        w.req.read_length    = len;
        w.req.read_offset    = off;
        w.req.callback_tag   = tag;
        w.req.short_callback = shrt;
        w.req.user_word      = uword;
        w.req.user_flag      = uflag;
        w.done               = $urandom;
        return w;
    endfunction

    function automatic word_t make_done(input logic [31:0] outcome);
        word_t w;
        w = make_enq(1'($urandom_range(1)), 5'($urandom_range(31)), $urandom, $urandom,
                     $urandom, $urandom, 1'($urandom_range(1)), $urandom,
                     8'($urandom_range(255)));
        w.func = FUNC_COMPLETE;
        w.done = outcome;
        return w;
    endfunction

    task automatic send_word(input word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid          <= 1'b1;
        request_ch.func           <= w.func;
        request_ch.priority_req   <= w.prio;
        request_ch.file_slot      <= w.req.file_slot;
        request_ch.buf_addr       <= w.req.buf_addr;
        request_ch.read_length    <= w.req.read_length;
        request_ch.read_offset    <= w.req.read_offset;
        request_ch.callback_tag   <= w.req.callback_tag;
        request_ch.short_callback <= w.req.short_callback;
        request_ch.user_word      <= w.req.user_word;
        request_ch.user_flag      <= w.req.user_flag;
        request_ch.done_result    <= w.done;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    task automatic run_phase(input int sidle, input int ridle, input bit with_hold);
        int          n;
        int          enq_pct;
        word_t       w;
        logic [31:0] d;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        if (with_hold)
            hold_requests++;
        n       = 0;
        enq_pct = 55;
        while (n < PHASE_WORDS)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: enq_pct = 30;
                    1: enq_pct = 55;
                    default: enq_pct = 85;
                endcase
            end
            n++;
            if ($urandom_range(99) < enq_pct)
                w = make_enq(1'($urandom_range(1)), 5'($urandom_range(31)), pick32(),
                             pick32(), pick32(), ($urandom_range(3) == 0) ? 32'h0 : pick32(),
                             1'($urandom_range(1)), pick32(), 8'($urandom_range(255)));
            else
            begin
                d     = pick32();
                d[31] = ($urandom_range(99) < 20);
                w     = make_done(d);
            end
            send_word(w);
        end
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        rst_n = 1'b0;
        request_ch.valid          <= 1'b0;
        request_ch.func           <= FUNC_ENQUEUE;
        request_ch.priority_req   <= 1'b0;
        request_ch.file_slot      <= '0;
        request_ch.buf_addr       <= '0;
        request_ch.read_length    <= '0;
        request_ch.read_offset    <= '0;
        request_ch.callback_tag   <= '0;
        request_ch.short_callback <= 1'b0;
        request_ch.user_word      <= '0;
        request_ch.user_flag      <= '0;
        request_ch.done_result    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drop: completion with nothing in flight
        send_word(make_done(32'd5));
        send_word(make_enq(1'b1, 5'd31, '1, '1, '1, '1, 1'b1, 32'h7fff_ffff, 8'hff));
        send_word(make_enq(1'b0, 5'd0, '0, '0, '0, '0, 1'b0, 32'h8000_0000, 8'h00));
        send_word(make_done(32'h8000_0000));
        send_word(make_done(32'hffff_ffff));
        send_word(make_done(32'h0000_0000));
        send_word(make_done(32'h7fff_ffff));
        // fill the urgent queue past its depth
        for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
            send_word(make_enq(1'b0, 5'(i), $urandom, $urandom, $urandom, 32'(i),
                               i[0], $urandom, 8'($urandom_range(255))));
        send_word(make_enq(1'b1, 5'd17, $urandom, $urandom, $urandom, 32'h0, 1'b1,
                           $urandom, 8'h5a));
        send_word(make_enq(1'b1, 5'd3, $urandom, $urandom, $urandom, 32'h1234_5678, 1'b0,
                           32'hffff_ffff, 8'ha5));
        send_word(make_done(32'd100));
        send_word(make_done(32'hffff_fff0));
        send_word(make_done(32'd1));
        send_word(make_done(32'd0));

        run_phase(18, 74, 1'b0);
        run_phase(74, 18, 1'b0);
        run_phase(0, 0, 1'b1);

        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
